@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the framebuffer modules.
// Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ZFB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zfb: implication violated");

// Condition that must never be seen outside reset.
`define ZFB_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("zfb: forbidden condition seen");

`endif

@@ rtl/zfb_pkg.sv @@
package zfb_pkg;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 12;
  localparam int COLOR_W   = 16;
  localparam int DEPTH_W   = 24;
  // Frame registers are 9 bits, so an index or a pixel count stays below 2**18.
  localparam int IDX_W     = 2 * CFG_W;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [2:0] MODE_WRITE     = 3'd0;
  localparam logic [2:0] MODE_READ      = 3'd1;
  localparam logic [2:0] MODE_CLR_COLOR = 3'd2;
  localparam logic [2:0] MODE_CLR_DEPTH = 3'd3;
  localparam logic [2:0] MODE_CLR_BOTH  = 3'd4;

  localparam logic [2:0] ST_WRITTEN = 3'd0;
  localparam logic [2:0] ST_OUT     = 3'd1;
  localparam logic [2:0] ST_REJECT  = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_CLEAR   = 3'd4;

  typedef enum logic [2:0] {
    K_WRITE,
    K_READ,
    K_READ_OOB,
    K_CLEAR,
    K_OOB
  } op_kind_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_ACCESS,
    BK_CLEAR
  } bk_state_t;

  typedef struct packed {
    logic [2:0]                mode;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic [COLOR_W-1:0]        pixel_color;
    logic [DEPTH_W-1:0]        pixel_depth;
    logic                      depth_test_enable;
  } zfb_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [COLOR_W-1:0] read_color;
    logic [DEPTH_W-1:0] read_depth;
  } zfb_out_t;

  // One classified operation; idx is the pixel index, or the pixel count of a clear.
  typedef struct packed {
    op_kind_t           kind;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
    logic [DEPTH_W-1:0] depth;
    logic               test;
    logic               clr_color;
    logic               clr_depth;
  } zfb_op_t;

endpackage

@@ rtl/zfb_front.sv @@
module zfb_front
  import zfb_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 start,
  input  zfb_in_t              in_item,
  output logic                 busy,
  input  logic [Q_CW-1:0]      q_count,
  input  logic                 init_busy,
  output logic                 q_push,
  output zfb_op_t              q_wdata
);

  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic             s1_valid_r;
  zfb_op_t          s1_op_r, s1_op_nxt;
  logic [CFG_W-1:0] s1_x_r, s1_x_nxt;

  logic [CFG_W-1:0] eff_w, eff_h;
  logic             x_ok, y_ok, in_frame;
  logic [CFG_W-1:0] mul_b;
  logic [IDX_W-1:0] prod;
  logic [Q_CW:0]    slots_used;
  logic             accept;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_nxt  = cfg_wdata;
        REG_FRAME_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate the frame size to the store geometry.
  assign eff_w = (int'(width_r) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_r;
  assign eff_h = (int'(height_r) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_r;

  assign x_ok     = !in_item.x_pos[COORD_W-1] &&
                    (in_item.x_pos[COORD_W-2:0] < (COORD_W-1)'(eff_w));
  assign y_ok     = !in_item.y_pos[COORD_W-1] &&
                    (in_item.y_pos[COORD_W-2:0] < (COORD_W-1)'(eff_h));
  assign in_frame = x_ok && y_ok;

  // Row offset for pixels, pixel count for clears.
  assign mul_b = ((in_item.mode == MODE_CLR_COLOR) || (in_item.mode == MODE_CLR_DEPTH) ||
                  (in_item.mode == MODE_CLR_BOTH)) ? eff_h : in_item.y_pos[CFG_W-1:0];
  assign prod  = {{CFG_W{1'b0}}, eff_w} * {{CFG_W{1'b0}}, mul_b};

  // Hold off while the queue plus the stage in flight would fill it.
  assign slots_used = {1'b0, q_count} + (Q_CW+1)'(s1_valid_r);
  assign busy       = init_busy || (slots_used >= (Q_CW+1)'(Q_DEPTH));
  assign accept     = start && !busy;

  always_comb begin
    s1_op_nxt.idx       = prod;
    s1_op_nxt.color     = in_item.pixel_color;
    s1_op_nxt.depth     = in_item.pixel_depth;
    s1_op_nxt.test      = in_item.depth_test_enable;
    s1_op_nxt.clr_color = 1'b0;
    s1_op_nxt.clr_depth = 1'b0;
    s1_x_nxt            = '0;
    case (in_item.mode)
      MODE_WRITE: begin
        s1_op_nxt.kind = in_frame ? K_WRITE : K_OOB;
        s1_x_nxt       = in_item.x_pos[CFG_W-1:0];
      end
      MODE_READ: begin
        s1_op_nxt.kind = in_frame ? K_READ : K_READ_OOB;
        s1_x_nxt       = in_item.x_pos[CFG_W-1:0];
      end
      MODE_CLR_COLOR: begin
        s1_op_nxt.kind      = K_CLEAR;
        s1_op_nxt.clr_color = 1'b1;
      end
      MODE_CLR_DEPTH: begin
        s1_op_nxt.kind      = K_CLEAR;
        s1_op_nxt.clr_depth = 1'b1;
      end
      MODE_CLR_BOTH: begin
        s1_op_nxt.kind      = K_CLEAR;
        s1_op_nxt.clr_color = 1'b1;
        s1_op_nxt.clr_depth = 1'b1;
      end
      default: s1_op_nxt.kind = K_OOB;
    endcase
  end

  always_comb begin
    q_wdata     = s1_op_r;
    q_wdata.idx = s1_op_r.idx + IDX_W'(s1_x_r);
  end
  assign q_push = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= CFG_W'(256);
      height_r   <= CFG_W'(256);
      s1_valid_r <= 1'b0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r <= s1_op_nxt;
      s1_x_r  <= s1_x_nxt;
    end
  end

endmodule

@@ rtl/zfb_queue.sv @@
`include "assert_macros.svh"

module zfb_queue
  import zfb_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  zfb_op_t         wdata,
  input  logic            pop,
  output zfb_op_t         head,
  output logic            empty,
  output logic [Q_CW-1:0] count
);

  zfb_op_t         ent_r [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  assign head  = ent_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

  `ZFB_ASSERT_NEVER(a_q_overflow, push && !pop && (count_r == Q_CW'(Q_DEPTH)))
  `ZFB_ASSERT_NEVER(a_q_underflow, pop && (count_r == '0))

endmodule

@@ rtl/zfb_back.sv @@
`include "assert_macros.svh"

module zfb_back
  import zfb_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  zfb_op_t  q_head,
  input  logic     q_empty,
  output logic     q_pop,
  output logic     init_busy,
  output logic     out_strobe,
  output zfb_out_t out_item
);

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int CW    = $clog2(STORE + 1);
  localparam logic [DEPTH_BITS-1:0] FAR_DEPTH = '1;

  bk_state_t state_r, state_nxt;
  zfb_op_t   op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic          out_valid_r, out_valid_nxt;
  zfb_out_t      out_item_r, out_item_nxt;

  logic [COLOR_W-1:0]    color_mem [STORE];
  logic [DEPTH_BITS-1:0] depth_mem [STORE];
  logic [AW-1:0]         mem_addr;
  logic                  c_we, d_we;
  logic [COLOR_W-1:0]    c_wdata;
  logic [DEPTH_BITS-1:0] d_wdata;
  logic [COLOR_W-1:0]    c_rdata_r;
  logic [DEPTH_BITS-1:0] d_rdata_r;
  logic [DEPTH_BITS-1:0] op_depth;

  assign op_depth = DEPTH_BITS'(op_r.depth);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_INIT: begin
        if (cnt_r == end_r) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          case (q_head.kind)
            K_WRITE, K_READ: state_nxt = BK_ACCESS;
            K_CLEAR:         state_nxt = BK_CLEAR;
            default:         state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_ACCESS: state_nxt = BK_IDLE;
      BK_CLEAR: begin
        if (cnt_r == end_r) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    end_nxt       = end_r;
    mem_addr      = cnt_r[AW-1:0];
    c_we          = 1'b0;
    d_we          = 1'b0;
    c_wdata       = op_r.color;
    d_wdata       = op_depth;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    case (state_r)
      BK_INIT: begin
        // Power-up pass: black and far over the whole store.
        c_wdata = '0;
        d_wdata = FAR_DEPTH;
        if (cnt_r != end_r) begin
          c_we    = 1'b1;
          d_we    = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          op_nxt   = q_head;
          mem_addr = AW'(q_head.idx);
          cnt_nxt  = '0;
          end_nxt  = CW'(q_head.idx);
          case (q_head.kind)
            K_OOB: begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_OUT;
            end
            K_READ_OOB: begin
              out_valid_nxt           = 1'b1;
              out_item_nxt.status     = ST_READ;
              out_item_nxt.read_depth = DEPTH_W'(FAR_DEPTH);
            end
            default: ;
          endcase
        end
      end
      BK_ACCESS: begin
        // Stored pixel is in the read registers now.
        mem_addr      = AW'(op_r.idx);
        out_valid_nxt = 1'b1;
        case (op_r.kind)
          K_READ: begin
            out_item_nxt.status     = ST_READ;
            out_item_nxt.read_color = c_rdata_r;
            out_item_nxt.read_depth = DEPTH_W'(d_rdata_r);
          end
          K_WRITE: begin
            if (op_r.test && (op_depth >= d_rdata_r)) begin
              out_item_nxt.status = ST_REJECT;
            end else begin
              c_we                = 1'b1;
              d_we                = 1'b1;
              out_item_nxt.status = ST_WRITTEN;
            end
          end
          default: out_item_nxt.status = ST_OUT;
        endcase
      end
      BK_CLEAR: begin
        if (cnt_r != end_r) begin
          c_we    = op_r.clr_color;
          d_we    = op_r.clr_depth;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = ST_CLEAR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      cnt_r       <= '0;
      end_r       <= CW'(STORE);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      color_mem[mem_addr] <= c_wdata;
    end
    c_rdata_r <= color_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      depth_mem[mem_addr] <= d_wdata;
    end
    d_rdata_r <= depth_mem[mem_addr];
  end

  assign init_busy  = (state_r == BK_INIT);
  assign out_strobe = out_valid_r;
  assign out_item   = out_item_r;

  `ZFB_ASSERT_IMP(a_pop_only_idle, q_pop, state_r == BK_IDLE)
  `ZFB_ASSERT_IMP(a_sweep_bound, (state_r == BK_CLEAR) || (state_r == BK_INIT), cnt_r <= end_r)
  `ZFB_ASSERT_IMP(a_quiet_init, state_r == BK_INIT, !out_valid_r)

endmodule

@@ rtl/zbuffer_framebuffer.sv @@
// Colour and depth framebuffer with a less-than depth test. A transaction is
// taken when start is high and busy is low; every transaction gives exactly one
// result, shown for one cycle with out_strobe, and the receiver cannot stall it.
// After reset the block sweeps the whole store to black and far depth, one pixel
// a cycle, holding busy high until the sweep is done (configuration writes are
// taken during that time). Transactions are classified and sized in one front
// register stage and queued, up to four deep, for the store sequencer. Out of
// bounds and unused modes are answered straight from the idle state; reads and
// fragment writes pass an access state, set by the single store port (read the
// pixel, then write it back). A clear sweeps active width times active height
// pixels, one pixel per cycle. A result goes through the front register, the
// queue and the sequencer, and is registered before out_strobe shows it.
module zbuffer_framebuffer
  import zfb_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 start,
  input  zfb_in_t              in_item,
  output logic                 busy,
  output logic                 out_strobe,
  output zfb_out_t             out_item
);

  zfb_op_t         q_wdata, q_head;
  logic            q_push, q_pop, q_empty;
  logic [Q_CW-1:0] q_count;
  logic            init_busy;

  zfb_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .q_count  (q_count),
    .init_busy(init_busy),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  zfb_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .head (q_head),
    .empty(q_empty),
    .count(q_count)
  );

  zfb_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .DEPTH_BITS(DEPTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

endmodule

@@ tb/sv/zbuffer_framebuffer_test.sv @@
module zbuffer_framebuffer_test;
  import zfb_pkg::*;

  localparam int STORE_N    = 256 * 256;
  localparam int EDGE_MAX_W = 256;
  localparam int EDGE_MAX_H = 256;
  localparam logic [DEPTH_W-1:0] FAR_DEPTH = {DEPTH_W{1'b1}};
  localparam int CLEAR_AREA_MAX = 4096;
  localparam int DRAIN_CYCLES   = 16;

  class zfb_scoreboard;
    bit [COLOR_W-1:0] color_mem [STORE_N];
    bit [DEPTH_W-1:0] depth_mem [STORE_N];
    bit [CFG_W-1:0]   width_reg;
    bit [CFG_W-1:0]   height_reg;
    zfb_out_t         pending_results [$];
    int               n_errors;
    int               n_checked;
    int               status_count [8];

    function new();
      for (int i = 0; i < STORE_N; i++) begin
        color_mem[i] = '0;
        depth_mem[i] = FAR_DEPTH;
      end
      width_reg  = 9'd256;
      height_reg = 9'd256;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      if (idx == REG_FRAME_WIDTH) width_reg = v;
      else height_reg = v;
    endfunction

    function int active_w();
      return (width_reg > EDGE_MAX_W) ? EDGE_MAX_W : int'(width_reg);
    endfunction

    function int active_h();
      return (height_reg > EDGE_MAX_H) ? EDGE_MAX_H : int'(height_reg);
    endfunction

    function bit locate(int x, int y, output int idx);
      idx = 0;
      if (x < 0 || y < 0 || x >= active_w() || y >= active_h()) return 1'b0;
      idx = y * active_w() + x;
      return idx < STORE_N;
    endfunction

    function logic [DEPTH_W-1:0] peek_depth(int x, int y);
      int idx;
      if (locate(x, y, idx)) return depth_mem[idx];
      return FAR_DEPTH;
    endfunction

    // Apply one accepted request to the shadow stores and queue its answer.
    function void note_request(zfb_in_t t);
      zfb_out_t r;
      int       idx;
      int       n;
      bit       hit;
      r   = '0;
      hit = locate($signed(t.x_pos), $signed(t.y_pos), idx);
      case (t.mode)
        MODE_WRITE: begin
          if (!hit) r.status = ST_OUT;
          else if (t.depth_test_enable && t.pixel_depth >= depth_mem[idx]) r.status = ST_REJECT;
          else begin
            color_mem[idx] = t.pixel_color;
            depth_mem[idx] = t.pixel_depth;
            r.status = ST_WRITTEN;
          end
        end
        MODE_READ: begin
          r.status = ST_READ;
          r.read_color = hit ? color_mem[idx] : '0;
          r.read_depth = hit ? depth_mem[idx] : FAR_DEPTH;
        end
        MODE_CLR_COLOR, MODE_CLR_DEPTH, MODE_CLR_BOTH: begin
          n = active_w() * active_h();
          if (n > STORE_N) n = STORE_N;
          for (int i = 0; i < n; i++) begin
            if (t.mode != MODE_CLR_DEPTH) color_mem[i] = t.pixel_color;
            if (t.mode != MODE_CLR_COLOR) depth_mem[i] = t.pixel_depth;
          end
          r.status = ST_CLEAR;
        end
        default: r.status = ST_OUT;
      endcase
      status_count[r.status]++;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      n_errors++;
    endtask

    task check_result(zfb_out_t got);
      zfb_out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending, status %0d", got.status));
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.read_color !== want.read_color)
        report($sformatf("read_color %h, want %h", got.read_color, want.read_color));
      if (got.read_depth !== want.read_depth)
        report($sformatf("read_depth %h, want %h", got.read_depth, want.read_depth));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 start;
  zfb_in_t              in_item;
  logic                 busy;
  logic                 out_strobe;
  zfb_out_t             out_item;

  zfb_scoreboard sb;
  int            idle_pct;

  zbuffer_framebuffer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) sb.check_result(out_item);
  end

  function automatic zfb_in_t mk(logic [2:0] mode, int x, int y, logic [COLOR_W-1:0] c,
                                 logic [DEPTH_W-1:0] d, logic test);
    zfb_in_t t;
    t.mode              = mode;
    t.x_pos             = x[COORD_W-1:0];
    t.y_pos             = y[COORD_W-1:0];
    t.pixel_color       = c;
    t.pixel_depth       = d;
    t.depth_test_enable = test;
    return t;
  endfunction

  function automatic zfb_in_t junk_item();
    return mk(3'($urandom_range(7, 0)), $urandom_range(4095, 0), $urandom_range(4095, 0),
              COLOR_W'($urandom_range(65535, 0)), DEPTH_W'($urandom_range(FAR_DEPTH, 0)),
              1'($urandom_range(1, 0)));
  endfunction

  // Mostly in-frame traffic with depths close to what is stored, plus noise.
  function automatic zfb_in_t random_request();
    zfb_in_t t;
    int      w, h, r, x, y;
    logic [DEPTH_W-1:0] d;
    w = sb.active_w();
    h = sb.active_h();
    t = junk_item();
    r = $urandom_range(99, 0);
    if (r < 42) t.mode = MODE_WRITE;
    else if (r < 78) t.mode = MODE_READ;
    else if (r < 88) begin
      if (w * h <= CLEAR_AREA_MAX) t.mode = 3'($urandom_range(MODE_CLR_BOTH, MODE_CLR_COLOR));
      else t.mode = MODE_READ;
    end else if (r < 92) t.mode = 3'($urandom_range(7, 5));
    else if (w * h > CLEAR_AREA_MAX && t.mode inside {MODE_CLR_COLOR, MODE_CLR_DEPTH,
                                                       MODE_CLR_BOTH})
      t.mode = MODE_WRITE;
    r = $urandom_range(99, 0);
    if (w > 0 && h > 0 && r < 85) begin
      x = $urandom_range(w - 1, 0);
      y = $urandom_range(h - 1, 0);
      t.x_pos = x[COORD_W-1:0];
      t.y_pos = y[COORD_W-1:0];
    end else if (r < 92) begin
      // just outside an edge
      case ($urandom_range(3, 0))
        0: t.x_pos = -12'sd1;
        1: t.y_pos = -12'sd1;
        2: t.x_pos = w[COORD_W-1:0];
        default: t.y_pos = h[COORD_W-1:0];
      endcase
    end
    d = sb.peek_depth($signed(t.x_pos), $signed(t.y_pos));
    r = $urandom_range(99, 0);
    if (r < 6) t.pixel_depth = d;
    else if (r < 11) t.pixel_depth = d + 1'b1;
    else if (r < 16) t.pixel_depth = d - 1'b1;
    else if (r < 20) t.pixel_depth = '0;
    else if (r < 24) t.pixel_depth = FAR_DEPTH;
    t.depth_test_enable = ($urandom_range(99, 0) < 75);
    return t;
  endfunction

  task automatic send_request(zfb_in_t t);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= t;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(t);
  endtask

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= junk_item();
    end
  endtask

  task automatic send_paced(zfb_in_t t);
    if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) idle_sender($urandom_range(3, 1));
    send_request(t);
  endtask

  // Drop start and wait for every outstanding answer, then let the pipe settle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(int w, int h);
    write_reg(REG_FRAME_WIDTH, w[CFG_W-1:0]);
    write_reg(REG_FRAME_HEIGHT, h[CFG_W-1:0]);
  endtask

  int frame_w_list [8] = '{8, 1, 16, 511, 0, 256, 5, 37};
  int frame_h_list [8] = '{8, 1, 5, 2, 7, 256, 300, 11};
  int idle_list    [4] = '{0, 51, 0, 13};

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    start     = 1'b0;
    in_item   = '0;
    idle_pct  = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: corners, depth test edges, off-frame coordinates, unused modes, clears.
    set_frame(256, 256);
    send_request(mk(MODE_WRITE, 0, 0, 16'hFFFF, '0, 1'b1));
    send_request(mk(MODE_WRITE, 0, 0, 16'h1234, '0, 1'b1));
    send_request(mk(MODE_WRITE, 0, 0, 16'h1234, FAR_DEPTH, 1'b0));
    send_request(mk(MODE_READ, 0, 0, '0, '0, 1'b0));
    send_request(mk(MODE_WRITE, 255, 255, '0, FAR_DEPTH - 1'b1, 1'b1));
    send_request(mk(MODE_READ, 255, 255, 16'hFFFF, FAR_DEPTH, 1'b1));
    send_request(mk(MODE_WRITE, -1, 0, 16'h0F0F, 24'h000001, 1'b1));
    send_request(mk(MODE_READ, 256, 5, 16'h0F0F, 24'h000001, 1'b0));
    send_request(mk(MODE_WRITE, 0, -2048, 16'hF0F0, 24'h800000, 1'b0));
    send_request(mk(MODE_READ, 2047, 2047, '0, '0, 1'b0));
    send_request(mk(3'd5, 3, 3, 16'hBEEF, 24'h123456, 1'b0));
    send_request(mk(3'd6, 4, 4, 16'hBEEF, 24'h123456, 1'b1));
    send_request(mk(3'd7, 5, 5, 16'hBEEF, 24'h123456, 1'b0));
    send_request(mk(MODE_CLR_BOTH, 0, 0, 16'hFFFF, '0, 1'b0));
    send_request(mk(MODE_READ, 128, 77, '0, '0, 1'b0));
    drain();
    set_frame(511, 2);
    send_request(mk(MODE_WRITE, 255, 1, 16'h7777, 24'h000001, 1'b1));
    send_request(mk(MODE_WRITE, 256, 0, 16'h7777, 24'h000001, 1'b0));
    send_request(mk(MODE_CLR_COLOR, 9, 9, 16'h5A5A, 24'h000000, 1'b0));
    send_request(mk(MODE_CLR_DEPTH, 9, 9, 16'h0000, FAR_DEPTH, 1'b0));
    send_request(mk(MODE_READ, 255, 1, '0, '0, 1'b0));
    send_request(mk(MODE_READ, 0, 2, '0, '0, 1'b0));
    drain();
    set_frame(0, 256);
    send_request(mk(MODE_WRITE, 0, 0, 16'h1111, '0, 1'b0));
    send_request(mk(MODE_CLR_BOTH, 0, 0, 16'h2222, 24'h333333, 1'b0));
    send_request(mk(MODE_READ, 0, 0, '0, '0, 1'b0));
    drain();

    for (int p = 0; p < 8; p++) begin
      set_frame(frame_w_list[p], frame_h_list[p]);
      idle_pct = idle_list[p % 4];
      for (int i = 0; i < 240; i++) begin
        // alternate bursts with no pacing so back-to-back traffic shows up in every phase
        if ((i / 40) % 2 == 1 && idle_pct != 0) send_request(random_request());
        else send_paced(random_request());
      end
      drain();
    end

    $display("Checked %0d results: %0d written, %0d depth-rejected, %0d out of bounds/unused,",
             sb.n_checked, sb.status_count[ST_WRITTEN], sb.status_count[ST_REJECT],
             sb.status_count[ST_OUT]);
    $display("  %0d reads and %0d clears over 11 frame sizes, sender idle 0/13/51 percent",
             sb.status_count[ST_READ], sb.status_count[ST_CLEAR]);
    if (sb.n_errors == 0 && sb.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/zfb_pkg.sv
rtl/zfb_front.sv
rtl/zfb_queue.sv
rtl/zfb_back.sv
rtl/zbuffer_framebuffer.sv
tb/sv/zbuffer_framebuffer_test.sv
